@@ src/rrce_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrce_pkg
// Shared types and constants of the row record column extractor.
// ----------------------------------------------------------------------------
package rrce_pkg;

  localparam int MAX_COLUMNS_DEF = 16;

  localparam int COUNT_W = 5;
  localparam int SEL_W   = 4;
  localparam int TYPES_W = 64;
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 2;

  localparam int BYTE_W  = 8;
  localparam int DATA_W  = 64;
  localparam int NB_W    = 4;
  localparam int LEN_W   = 16;
  localparam int ERR_W   = 2;
  localparam int CODE_W  = 4;
  localparam int PH_W    = 3;

  // packed output word: data, byte count, field length, error code, pad
  localparam int OUT_W      = DATA_W + NB_W + LEN_W + ERR_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SELECTED_COLUMN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_TYPES    = 2'd2;

  // column type codes
  localparam logic [CODE_W-1:0] TY_INT8    = 4'd0;
  localparam logic [CODE_W-1:0] TY_INT16   = 4'd1;
  localparam logic [CODE_W-1:0] TY_INT32   = 4'd2;
  localparam logic [CODE_W-1:0] TY_INT64   = 4'd3;
  localparam logic [CODE_W-1:0] TY_FLOAT32 = 4'd4;
  localparam logic [CODE_W-1:0] TY_FLOAT64 = 4'd5;
  localparam logic [CODE_W-1:0] TY_DECIMAL = 4'd6;
  localparam logic [CODE_W-1:0] TY_BOOL    = 4'd7;
  localparam logic [CODE_W-1:0] TY_STRING  = 4'd8;
  localparam logic [CODE_W-1:0] TY_BLOB    = 4'd9;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_DECIMAL = 2'd1;
  localparam logic [ERR_W-1:0] ERR_BLOB    = 2'd2;
  localparam logic [ERR_W-1:0] ERR_UNKNOWN = 2'd3;

  // parse phases
  localparam logic [PH_W-1:0] PH_PRESENCE = 3'd0;
  localparam logic [PH_W-1:0] PH_NUMERIC  = 3'd1;
  localparam logic [PH_W-1:0] PH_LEN_HI   = 3'd2;
  localparam logic [PH_W-1:0] PH_LEN_LO   = 3'd3;
  localparam logic [PH_W-1:0] PH_STRING   = 3'd4;

  localparam logic [DATA_W-1:0] NAN32 = 64'h0000_0000_7FC0_0000;
  localparam logic [DATA_W-1:0] NAN64 = 64'h7FF8_0000_0000_0000;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [NB_W-1:0]   nbytes;
    logic              field_end;
    logic [LEN_W-1:0]  len;
    logic [ERR_W-1:0]  err;
  } rrce_result_t;

  // payload size of a numeric type, 0 for the rest
  function automatic logic [NB_W-1:0] numeric_size(input logic [CODE_W-1:0] code);
    logic [NB_W-1:0] sz;
    unique case (code)
      TY_INT8, TY_BOOL:     sz = 4'd1;
      TY_INT16:             sz = 4'd2;
      TY_INT32, TY_FLOAT32: sz = 4'd4;
      TY_INT64, TY_FLOAT64: sz = 4'd8;
      default:              sz = 4'd0;
    endcase
    return sz;
  endfunction

endpackage

@@ src/rrce_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrce_parser
// Configuration registers and the per-byte field parser; one byte a cycle while take is high.
// ----------------------------------------------------------------------------
module rrce_parser #(
  parameter int MAX_COLUMNS = rrce_pkg::MAX_COLUMNS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rrce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrce_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          take,
  input  logic [rrce_pkg::BYTE_W-1:0]   in_byte,
  input  logic                          stream_start,
  output logic                          res_valid,
  output rrce_pkg::rrce_result_t        res
);
  import rrce_pkg::*;

  localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_COLUMNS);

  logic [COUNT_W-1:0] column_count;
  logic [SEL_W-1:0]   selected_column;
  logic [TYPES_W-1:0] column_types;

  logic [IDX_W-1:0]   column_index, column_index_next;
  logic [PH_W-1:0]    parse_phase, parse_phase_next;
  logic [LEN_W-1:0]   bytes_left, bytes_left_next;
  logic [DATA_W-1:0]  value_acc, value_acc_next;
  logic [LEN_W-1:0]   string_length, string_length_next;
  logic               error_hold, error_hold_next;

  logic [COUNT_W-1:0] eff_count;
  logic [COUNT_W-1:0] idx_inc;
  logic [IDX_W-1:0]   idx_wrap;
  logic [IDX_W-1:0]   ci;
  logic [PH_W-1:0]    ph;
  logic [LEN_W-1:0]   bl;
  logic [LEN_W-1:0]   bl_dec;
  logic [LEN_W-1:0]   slen;
  logic [DATA_W-1:0]  acc_shift;
  logic [CODE_W-1:0]  code;
  logic [NB_W-1:0]    nsize;
  logic               sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= COUNT_W'(1);
      selected_column <= '0;
      column_types    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLUMN_COUNT:    column_count    <= cfg_data[COUNT_W-1:0];
        REG_SELECTED_COLUMN: selected_column <= cfg_data[SEL_W-1:0];
        REG_COLUMN_TYPES:    column_types    <= cfg_data[TYPES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index  <= '0;
      parse_phase   <= PH_PRESENCE;
      bytes_left    <= '0;
      value_acc     <= '0;
      string_length <= '0;
      error_hold    <= 1'b0;
    end else begin
      column_index  <= column_index_next;
      parse_phase   <= parse_phase_next;
      bytes_left    <= bytes_left_next;
      value_acc     <= value_acc_next;
      string_length <= string_length_next;
      error_hold    <= error_hold_next;
    end
  end

  always_comb begin
    // zero acts as one, above the column limit acts as the limit
    if (column_count == '0)         eff_count = COUNT_W'(1);
    else if (column_count > MAX_CNT) eff_count = MAX_CNT;
    else                            eff_count = column_count;

    // a stream start restarts the row before the byte is looked at
    ci = stream_start ? '0 : column_index;
    ph = stream_start ? PH_PRESENCE : parse_phase;
    bl = stream_start ? '0 : bytes_left;

    idx_inc  = COUNT_W'(ci) + COUNT_W'(1);
    idx_wrap = (idx_inc >= eff_count) ? '0 : idx_inc[IDX_W-1:0];
    sel      = (SEL_W'(ci) == selected_column);
    code     = column_types[4*ci +: CODE_W];
    nsize    = numeric_size(code);
    bl_dec   = (bl != '0) ? bl - LEN_W'(1) : bl;
    acc_shift = {value_acc[DATA_W-BYTE_W-1:0], in_byte};
    slen     = {string_length[LEN_W-1:BYTE_W], in_byte};

    column_index_next  = column_index;
    parse_phase_next   = parse_phase;
    bytes_left_next    = bytes_left;
    value_acc_next     = value_acc;
    string_length_next = string_length;
    error_hold_next    = error_hold;
    res_valid          = 1'b0;
    res                = '0;

    if (take) begin
      column_index_next = ci;
      parse_phase_next  = ph;
      bytes_left_next   = bl;
      error_hold_next   = stream_start ? 1'b0 : error_hold;

      if (stream_start || !error_hold) begin
        unique case (ph)
          PH_PRESENCE: begin
            value_acc_next = '0;
            if (in_byte == '0) begin
              if (sel && code == TY_FLOAT32) begin
                res_valid = 1'b1;
                res.data = NAN32; res.nbytes = 4'd4; res.field_end = 1'b1;
                res.len = LEN_W'(4);
              end else if (sel && code == TY_FLOAT64) begin
                res_valid = 1'b1;
                res.data = NAN64; res.nbytes = 4'd8; res.field_end = 1'b1;
                res.len = LEN_W'(8);
              end else if (sel && code == TY_STRING) begin
                // null string: empty end marker
                res_valid = 1'b1;
                res.field_end = 1'b1;
              end
              column_index_next = idx_wrap;
              parse_phase_next  = PH_PRESENCE;
              bytes_left_next   = '0;
            end else if (code == TY_STRING) begin
              parse_phase_next = PH_LEN_HI;
            end else if (nsize != '0) begin
              parse_phase_next = PH_NUMERIC;
              bytes_left_next  = LEN_W'(nsize);
            end else begin
              error_hold_next = 1'b1;
              res_valid = 1'b1;
              if (code == TY_DECIMAL)   res.err = ERR_DECIMAL;
              else if (code == TY_BLOB) res.err = ERR_BLOB;
              else                      res.err = ERR_UNKNOWN;
            end
          end
          PH_NUMERIC: begin
            value_acc_next  = acc_shift;
            bytes_left_next = bl_dec;
            if (bl_dec == '0) begin
              if (sel) begin
                res_valid = 1'b1;
                res.data = acc_shift; res.nbytes = nsize; res.field_end = 1'b1;
                res.len = LEN_W'(nsize);
              end
              column_index_next = idx_wrap;
              parse_phase_next  = PH_PRESENCE;
              bytes_left_next   = '0;
            end
          end
          PH_LEN_HI: begin
            string_length_next = {in_byte, {BYTE_W{1'b0}}};
            parse_phase_next   = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            string_length_next = slen;
            if (slen == '0) begin
              if (sel) begin
                res_valid = 1'b1;
                res.field_end = 1'b1;
              end
              column_index_next = idx_wrap;
              parse_phase_next  = PH_PRESENCE;
              bytes_left_next   = '0;
            end else begin
              bytes_left_next  = slen;
              parse_phase_next = PH_STRING;
            end
          end
          PH_STRING: begin
            bytes_left_next = bl_dec;
            if (sel) begin
              res_valid = 1'b1;
              res.data = DATA_W'(in_byte); res.nbytes = 4'd1;
              res.field_end = (bl_dec == '0);
              res.len = (bl_dec == '0) ? string_length : '0;
            end
            if (bl_dec == '0) begin
              column_index_next = idx_wrap;
              parse_phase_next  = PH_PRESENCE;
              bytes_left_next   = '0;
            end
          end
          default: begin
            parse_phase_next = PH_PRESENCE;
          end
        endcase
      end
    end
  end

endmodule

@@ src/rrce_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrce_out_stage
// Result register with a skid entry, so one more result is taken on a stall before can_push drops.
// ----------------------------------------------------------------------------
module rrce_out_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  rrce_pkg::rrce_result_t push_res,
  output logic                   can_push,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rrce_pkg::rrce_result_t out_res
);
  import rrce_pkg::*;

  logic         skid_valid;
  rrce_result_t skid_res;

  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_res <= skid_valid ? skid_res : push_res;
    end else if (push) begin
      skid_res <= push_res;
    end
  end

endmodule

@@ src/row_record_column_extractor_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_record_column_extractor_top
// Parses a byte stream of row records and emits the values of one column.
// ----------------------------------------------------------------------------
// Input channel s_*: one stream byte per word, s_tuser marks the first byte
// of a new stream (restarts at column 0 and clears a held error).
// Output channel m_*: at most one word per input byte; m_tlast marks the
// last word of a selected field. Numerics come out whole, strings one byte
// per word with the length on the last word, null floats as quiet NaN.
// An unsupported type gives one error word, then bytes are dropped until
// the next stream start.
// Configuration: cfg_we, cfg_index, cfg_data write column_count (0),
// selected_column (1) and column_types (2); the user must write them only
// while the block is idle; the block does not enforce it. Throughput: one
// byte per cycle while s_tready is high; m_* is driven from a register.
// If the receiver stalls, one more result is caught in a skid entry and
// s_tready drops until it drains. Synchronous reset empties the output,
// restores register defaults and puts the parser at column 0.
// ----------------------------------------------------------------------------
module row_record_column_extractor_top #(
  parameter int MAX_COLUMNS = rrce_pkg::MAX_COLUMNS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rrce_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rrce_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [rrce_pkg::BYTE_W-1:0]      s_tdata,   // in_byte
  input  logic                             s_tuser,   // stream_start
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // extracted_value[63:0], out_bytes[67:64], field_len[83:68], error_code[85:84]
  output logic [rrce_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                             m_tlast    // field_end
);
  import rrce_pkg::*;

  logic         take;
  logic         res_valid;
  rrce_result_t res;
  rrce_result_t out_res;

  assign take = s_tvalid && s_tready;

  rrce_parser #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .take         (take),
    .in_byte      (s_tdata),
    .stream_start (s_tuser),
    .res_valid    (res_valid),
    .res          (res)
  );

  rrce_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (take && res_valid),
    .push_res  (res),
    .can_push  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {{(OUT_TDATA_W-OUT_W){1'b0}}, out_res.err, out_res.len,
                    out_res.nbytes, out_res.data};
  assign m_tlast = out_res.field_end;

endmodule
